/* design/pmfb_pkg.sv */
// Shared constants, codes and command types of the page-mode pixel framebuffer.
`timescale 1ns / 1ps
`default_nettype none

package pmfb_pkg;

  // Display geometry: columns of bytes, each page a stack of eight rows.
  localparam int COLUMNS     = 128;
  localparam int PAGES       = 4;
  localparam int ROWS        = PAGES * 8;
  localparam int STORE_DEPTH = COLUMNS * PAGES;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Selects the bit of a byte from the low row bits.
  localparam logic [2:0] BIT_MASK = 3'h7;

  // Command queue between the front and back parts.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_WRITE_PIXEL = 2'd0,
    OP_CLEAR_ALL   = 2'd1,
    OP_INVERT      = 2'd2,
    OP_READ_BYTE   = 2'd3
  } op_t;

  // What the back part has to do for one item.
  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_CLEAR,
    CMD_INVERT,
    CMD_READ,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [STORE_AW-1:0]   addr;
    logic [2:0]            bit_sel;
    logic                  pixel;
    logic                  oor;
  } cmd_t;

endpackage

`default_nettype wire

/* design/pmfb_ifs.sv */
// Valid/ready channel interfaces for input items, results and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface pmfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] column;
  logic [5:0] row;
  logic       pixel_value;
  logic [1:0] page;

  modport source (output valid, op, column, row, pixel_value, page, input ready);
  modport sink (input valid, op, column, row, pixel_value, page, output ready);
endinterface

interface pmfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       out_of_range;

  modport source (output valid, read_byte, out_of_range, input ready);
  modport sink (input valid, read_byte, out_of_range, output ready);
endinterface

interface pmfb_cfg_if;
  logic valid;
  logic ready;
  logic invert_enable;

  modport source (output valid, invert_enable, input ready);
  modport sink (input valid, invert_enable, output ready);
endinterface

`default_nettype wire

/* design/pmfb_front.sv */
// Front part: accepts input items, checks coordinates and forms commands.
`timescale 1ns / 1ps
`default_nettype none

module pmfb_front (
  input  logic            invert_enable,
  input  logic            accept_en,
  pmfb_in_if.sink         in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output pmfb_pkg::cmd_t  push_cmd
);
  import pmfb_pkg::*;

  logic        col_ok;
  logic        row_ok;
  logic        page_ok;
  logic [2:0]  page_sel;
  logic [11:0] idx_wide;

  // Range checks and the byte address: column * PAGES + page.
  always_comb begin
    col_ok   = {1'b0, in_ch.column} < 9'(COLUMNS);
    row_ok   = {1'b0, in_ch.row} < 7'(ROWS);
    page_ok  = {2'b00, in_ch.page} < 4'(PAGES);
    page_sel = (op_t'(in_ch.op) == OP_READ_BYTE) ? {1'b0, in_ch.page} : in_ch.row[5:3];
    idx_wide = {4'b0000, in_ch.column} * 12'(PAGES) + {9'd0, page_sel};
  end

  // Classify the item into a command for the back part.
  always_comb begin
    push_cmd.kind    = CMD_REPORT;
    push_cmd.addr    = idx_wide[STORE_AW-1:0];
    push_cmd.bit_sel = in_ch.row[2:0] & BIT_MASK;
    push_cmd.pixel   = in_ch.pixel_value;
    push_cmd.oor     = 1'b0;
    case (op_t'(in_ch.op))
      OP_WRITE_PIXEL: begin
        if (col_ok && row_ok) begin
          push_cmd.kind = CMD_WRITE;
        end else begin
          push_cmd.oor = 1'b1;
        end
      end
      OP_CLEAR_ALL: begin
        push_cmd.kind = CMD_CLEAR;
      end
      OP_INVERT: begin
        push_cmd.kind = invert_enable ? CMD_INVERT : CMD_REPORT;
      end
      OP_READ_BYTE: begin
        if (col_ok && page_ok) begin
          push_cmd.kind = CMD_READ;
        end else begin
          push_cmd.oor = 1'b1;
        end
      end
      default: begin
        push_cmd.kind = CMD_REPORT;
      end
    endcase
  end

  // Handshake toward the queue; held off while the store is being initialized.
  assign push_valid  = in_ch.valid && accept_en;
  assign in_ch.ready = push_ready && accept_en;

endmodule

`default_nettype wire

/* design/pmfb_cmdq.sv */
// Short command queue that decouples the front part from the back part.
`timescale 1ns / 1ps
`default_nettype none

module pmfb_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  pmfb_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pmfb_pkg::cmd_t  pop_cmd
);
  import pmfb_pkg::*;

  cmd_t               entry_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_r;
  logic [CMDQ_AW-1:0] wr_ptr_nxt;
  logic [CMDQ_AW-1:0] rd_ptr_r;
  logic [CMDQ_AW-1:0] rd_ptr_nxt;
  logic [CMDQ_AW:0]   count_r;
  logic [CMDQ_AW:0]   count_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count_r != (CMDQ_AW + 1)'(CMDQ_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue entries hold payload only.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* design/pmfb_back.sv */
// Back part: executes commands against the frame store and drives results.
`timescale 1ns / 1ps
`default_nettype none

module pmfb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  pmfb_pkg::cmd_t  pop_cmd,
  output logic            init_busy,
  pmfb_out_if.source      out_ch
);
  import pmfb_pkg::*;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MODIFY,
    ST_FETCH
  } state_t;

  // The store keeps every byte XORed with the polarity bit, so an invert
  // only flips the polarity and a clear writes the polarity pattern.
  logic [7:0]          mem [STORE_DEPTH];
  logic [7:0]          mem_q_r;

  state_t              state_r;
  state_t              state_nxt;
  logic [STORE_AW-1:0] cnt_r;
  logic [STORE_AW-1:0] cnt_nxt;
  logic                sweep_rsp_r;
  logic                sweep_rsp_nxt;
  logic                pol_r;
  logic                pol_nxt;
  cmd_t                cur_r;
  cmd_t                cur_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [7:0]          out_byte_r;
  logic [7:0]          out_byte_nxt;
  logic                out_oor_r;
  logic                out_oor_nxt;

  logic                slot_free;
  logic                mem_we;
  logic                mem_re;
  logic [STORE_AW-1:0] mem_waddr;
  logic [STORE_AW-1:0] mem_raddr;
  logic [7:0]          mem_wdata;
  logic [7:0]          merged;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign init_busy = (state_r == ST_SWEEP) && !sweep_rsp_r;

  // Sequencer: sweeps, read-modify-write of one byte, readout, and reports.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sweep_rsp_nxt = sweep_rsp_r;
    pol_nxt       = pol_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_oor_nxt   = out_oor_r;
    pop_ready     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = {8{pol_r}};
    mem_raddr     = pop_cmd.addr;
    merged        = mem_q_r;
    merged[cur_r.bit_sel] = cur_r.pixel ^ pol_r;

    case (state_r)
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (cnt_r == STORE_AW'(STORE_DEPTH - 1)) begin
          // A clear command reports once the last byte is written.
          if (!sweep_rsp_r) begin
            state_nxt = ST_IDLE;
            cnt_nxt   = '0;
          end else if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = 8'd0;
            out_oor_nxt   = 1'b0;
            sweep_rsp_nxt = 1'b0;
            state_nxt     = ST_IDLE;
            cnt_nxt       = '0;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (pop_valid && slot_free) begin
          pop_ready = 1'b1;
          cur_nxt   = pop_cmd;
          case (pop_cmd.kind)
            CMD_WRITE: begin
              mem_re    = 1'b1;
              state_nxt = ST_MODIFY;
            end
            CMD_READ: begin
              mem_re    = 1'b1;
              state_nxt = ST_FETCH;
            end
            CMD_CLEAR: begin
              sweep_rsp_nxt = 1'b1;
              cnt_nxt       = '0;
              state_nxt     = ST_SWEEP;
            end
            CMD_INVERT: begin
              pol_nxt       = !pol_r;
              out_valid_nxt = 1'b1;
              out_byte_nxt  = 8'd0;
              out_oor_nxt   = 1'b0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_byte_nxt  = 8'd0;
              out_oor_nxt   = pop_cmd.oor;
            end
          endcase
        end
      end
      ST_MODIFY: begin
        if (slot_free) begin
          mem_we        = 1'b1;
          mem_waddr     = cur_r.addr;
          mem_wdata     = merged;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'd0;
          out_oor_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FETCH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = mem_q_r ^ {8{pol_r}};
          out_oor_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs; reset starts the initial clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      cnt_r       <= '0;
      sweep_rsp_r <= 1'b0;
      pol_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sweep_rsp_r <= sweep_rsp_nxt;
      pol_r       <= pol_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
      out_byte_r  <= out_byte_nxt;
      out_oor_r   <= out_oor_nxt;
    end
  end

  // Frame store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_byte    = out_byte_r;
  assign out_ch.out_of_range = out_oor_r;

endmodule

`default_nettype wire

/* design/page_mode_pixel_framebuffer.sv */
// Top level of the page-mode pixel framebuffer.
//
//  Channel  Direction  Carries
//  in_ch    sink       op, column, row, pixel_value, page
//  out_ch   source     read_byte, out_of_range
//  cfg_ch   sink       invert_enable
//
// A pixel write is a read-modify-write of one byte and a byte read a fetch from
// the single-port-read frame store. A clear writes every byte. After reset a
// clearing pass runs with in_ready low; configuration transfers are taken at
// any time. A two-entry command queue holds accepted items while a result
// waits for out_ready.
`timescale 1ns / 1ps
`default_nettype none

module page_mode_pixel_framebuffer (
  input  logic        clk,
  input  logic        rst_n,
  pmfb_in_if.sink     in_ch,
  pmfb_out_if.source  out_ch,
  pmfb_cfg_if.sink    cfg_ch
);
  import pmfb_pkg::*;

  logic invert_enable_r;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;
  logic init_busy;

  // Configuration register.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_enable_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      invert_enable_r <= cfg_ch.invert_enable;
    end
  end

  pmfb_front u_front (
    .invert_enable (invert_enable_r),
    .accept_en     (!init_busy),
    .in_ch         (in_ch),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_cmd      (push_cmd)
  );

  pmfb_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  pmfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

/* design/pmfb_checker.sv */
// Port-level checks of the framebuffer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pmfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_byte,
  input logic       out_of_range
);

  logic [2:0] pend_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Items accepted whose result has not been transferred yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      pend_r <= pend_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(read_byte) && $stable(out_of_range))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> pend_r != 3'd0)
    else $error("result without an accepted item");

  a_init: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("item accepted before the store was cleared");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_of_range |-> read_byte == 8'd0)
    else $error("out-of-range result carries data");

endmodule

bind page_mode_pixel_framebuffer pmfb_checker u_pmfb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .read_byte    (out_ch.read_byte),
  .out_of_range (out_ch.out_of_range)
);

`default_nettype wire
